FILE: rtl/radq_pkg.sv
// Shared types, codes and widths for the relative alarm delta queue.
`timescale 1ns / 1ps
`default_nettype none

package radq_pkg;

  // Default sizes of the alarm pool and the time values.
  localparam int NUM_ALARMS_DEF = 16;
  localparam int TIME_BITS_DEF  = 31;

  // Fixed widths of the stream fields.
  localparam int ACTION_W = 3;
  localparam int SLOT_W   = 4;
  localparam int DELAY_W  = 31;
  localparam int STATUS_W = 2;
  localparam int REM_W    = 31;

  localparam int S_FIELDS_W = SLOT_W + DELAY_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_FIELDS_W = STATUS_W + REM_W + 1 + SLOT_W + DELAY_W;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  // Action codes.
  localparam logic [ACTION_W-1:0] ACT_SCHEDULE   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_RESCHEDULE = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_CANCEL     = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_QUERY      = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_FREE   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_ACTIVE = 2'd2;

  // What the token traveling down the cell row is doing.
  typedef enum logic [2:0] {
    TOK_PASS,
    TOK_SEEK_INS,
    TOK_CARRY,
    TOK_SEEK_DEL,
    TOK_PULL,
    TOK_SUM
  } tok_mode_e;

  typedef struct packed {
    logic      valid;
    tok_mode_e mode;
  } tok_ctl_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/radq_cell.sv
// One position of the delta list, with the token stage that walks past it.
`timescale 1ns / 1ps
`default_nettype none

module radq_cell #(
  parameter int SLOT_BITS = 4,
  parameter int TIME_BITS = 31
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      clear,
  // Token from the left neighbor.
  input  radq_pkg::tok_ctl_t       tok_in,
  input  wire  [SLOT_BITS-1:0]     tok_in_slot,
  input  wire  [TIME_BITS-1:0]     tok_in_val,
  // Entry held by the right neighbor.
  input  wire                      nxt_valid,
  input  wire  [SLOT_BITS-1:0]     nxt_slot,
  input  wire  [TIME_BITS-1:0]     nxt_delta,
  // Token to the right neighbor.
  output radq_pkg::tok_ctl_t       tok_out,
  output logic [SLOT_BITS-1:0]     tok_out_slot,
  output logic [TIME_BITS-1:0]     tok_out_val,
  // Entry held here.
  output logic                     valid,
  output logic [SLOT_BITS-1:0]     slot,
  output logic [TIME_BITS-1:0]     delta
);

  import radq_pkg::*;

  logic                 valid_next;
  logic [SLOT_BITS-1:0] slot_next;
  logic [TIME_BITS-1:0] delta_next;
  tok_ctl_t             tok_next;
  logic [SLOT_BITS-1:0] tok_slot_next;
  logic [TIME_BITS-1:0] tok_val_next;
  logic [TIME_BITS:0]   sum_tok;
  logic [TIME_BITS:0]   sum_nxt;
  logic [TIME_BITS-1:0] sat_tok;
  logic [TIME_BITS-1:0] sat_nxt;
  logic                 le;
  logic                 hit;

  // Saturating sums for the query walk and for merging into the successor.
  assign sum_tok = {1'b0, tok_in_val} + {1'b0, delta};
  assign sum_nxt = {1'b0, nxt_delta} + {1'b0, delta};
  assign sat_tok = sum_tok[TIME_BITS] ? '1 : sum_tok[TIME_BITS-1:0];
  assign sat_nxt = sum_nxt[TIME_BITS] ? '1 : sum_nxt[TIME_BITS-1:0];

  assign le  = valid && (delta <= tok_in_val);
  assign hit = valid && (slot == tok_in_slot);

  // Token action at this position.
  always_comb begin
    valid_next    = valid;
    slot_next     = slot;
    delta_next    = delta;
    tok_next      = tok_in;
    tok_slot_next = tok_in_slot;
    tok_val_next  = tok_in_val;
    if (tok_in.valid) begin
      unique case (tok_in.mode)
        TOK_SEEK_INS: begin
          if (le) begin
            tok_val_next = tok_in_val - delta;
          end else begin
            // Insert here; the old entry moves right, shortened by the new delta.
            valid_next = 1'b1;
            slot_next  = tok_in_slot;
            delta_next = tok_in_val;
            if (valid) begin
              tok_next.mode = TOK_CARRY;
              tok_slot_next = slot;
              tok_val_next  = delta - tok_in_val;
            end else begin
              tok_next.mode = TOK_PASS;
            end
          end
        end
        TOK_CARRY: begin
          valid_next = 1'b1;
          slot_next  = tok_in_slot;
          delta_next = tok_in_val;
          if (valid) begin
            tok_slot_next = slot;
            tok_val_next  = delta;
          end else begin
            tok_next.mode = TOK_PASS;
          end
        end
        TOK_SEEK_DEL: begin
          if (hit) begin
            // Drop this entry; the successor moves in and absorbs its delta.
            valid_next    = nxt_valid;
            slot_next     = nxt_slot;
            delta_next    = nxt_valid ? sat_nxt : nxt_delta;
            tok_next.mode = nxt_valid ? TOK_PULL : TOK_PASS;
          end
        end
        TOK_PULL: begin
          valid_next    = nxt_valid;
          slot_next     = nxt_slot;
          delta_next    = nxt_delta;
          tok_next.mode = nxt_valid ? TOK_PULL : TOK_PASS;
        end
        TOK_SUM: begin
          tok_val_next = sat_tok;
          if (hit || !valid) begin
            tok_next.mode = TOK_PASS;
          end
        end
        TOK_PASS: begin
        end
        default: begin
          tok_next.mode = TOK_PASS;
        end
      endcase
    end
  end

  // Entry and token registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      tok_out <= '{valid: 1'b0, mode: TOK_PASS};
    end else begin
      valid   <= clear ? 1'b0 : valid_next;
      tok_out <= tok_next;
    end
    slot         <= slot_next;
    delta        <= delta_next;
    tok_out_slot <= tok_slot_next;
    tok_out_val  <= tok_val_next;
  end

endmodule

`default_nettype wire

FILE: rtl/relative_alarm_delta_queue.sv
// Top level of the relative alarm delta queue: sequencer, slot flags and the cell row.
// Schedule, cancel and query send one token down the row of NUM_ALARMS cells, and the
// result waits for the token to leave the row; reschedule sends two tokens (unlink,
// then insert). Rejected actions, clear and unknown actions send no token. A new word
// is taken in the cycle after the result loads, which waits on a full output.
// Synchronous reset frees all slots at once.
`timescale 1ns / 1ps
`default_nettype none

module relative_alarm_delta_queue #(
  parameter int NUM_ALARMS = radq_pkg::NUM_ALARMS_DEF,
  parameter int TIME_BITS  = radq_pkg::TIME_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              s_tvalid,
  output logic                             s_tready,
  // alarm_slot [3:0], delay [34:4], zero fill above
  input  wire  [radq_pkg::S_TDATA_W-1:0]   s_tdata,
  // action [2:0]
  input  wire  [radq_pkg::ACTION_W-1:0]    s_tuser,
  output logic                             m_tvalid,
  input  wire                              m_tready,
  // status [1:0], remaining [32:2], head_valid [33], head_slot [37:34],
  // head_delay [68:38], zero fill above
  output logic [radq_pkg::M_TDATA_W-1:0]   m_tdata
);

  import radq_pkg::*;

  localparam int SLOT_BITS = $clog2(NUM_ALARMS);

  // Cell row wiring.
  tok_ctl_t             tok_ctl  [0:NUM_ALARMS];
  logic [SLOT_BITS-1:0] tok_slot [0:NUM_ALARMS];
  logic [TIME_BITS-1:0] tok_val  [0:NUM_ALARMS];
  logic [NUM_ALARMS-1:0] cell_valid;
  logic [SLOT_BITS-1:0] cell_slot  [NUM_ALARMS];
  logic [TIME_BITS-1:0] cell_delta [NUM_ALARMS];
  logic                 nxt_valid  [NUM_ALARMS];
  logic [SLOT_BITS-1:0] nxt_slot   [NUM_ALARMS];
  logic [TIME_BITS-1:0] nxt_delta  [NUM_ALARMS];

  // Sequencer and operation registers.
  state_e                state;
  state_e                state_next;
  logic [NUM_ALARMS-1:0] active;
  tok_ctl_t              launch_ctl;
  logic [SLOT_BITS-1:0]  launch_slot;
  logic [TIME_BITS-1:0]  launch_val;
  logic [SLOT_BITS-1:0]  op_slot;
  logic [TIME_BITS-1:0]  op_time;
  logic [STATUS_W-1:0]   op_status;
  logic                  op_query;
  logic                  second;
  logic [TIME_BITS-1:0]  rem;

  // Input decode.
  logic [ACTION_W-1:0]   in_action;
  logic [SLOT_W-1:0]     in_slot_raw;
  logic [SLOT_BITS-1:0]  in_idx;
  logic [TIME_BITS-1:0]  in_time;
  logic                  in_range;
  logic                  in_act;
  logic                  run_req;
  logic [STATUS_W-1:0]   in_status;
  logic                  accept;
  logic                  clear_all;
  logic                  chain_done;
  logic                  out_free;
  logic                  head_valid;
  logic [SLOT_W-1:0]     head_slot;
  logic [DELAY_W-1:0]    head_delay;
  logic [REM_W-1:0]      remaining;

  assign in_action   = s_tuser;
  assign in_slot_raw = s_tdata[SLOT_W-1:0];
  assign in_idx      = SLOT_BITS'(in_slot_raw);
  assign in_time     = TIME_BITS'(s_tdata[SLOT_W +: DELAY_W]);
  assign in_range    = (32'(in_slot_raw) < NUM_ALARMS);
  assign in_act      = in_range && active[in_idx];

  assign accept     = s_tvalid && s_tready;
  assign clear_all  = accept && (in_action == ACT_CLEAR);
  assign chain_done = tok_ctl[NUM_ALARMS].valid;
  assign out_free   = !m_tvalid || m_tready;

  // Does the action need a walk of the list, and what does it report.
  always_comb begin
    run_req   = 1'b0;
    in_status = STAT_OK;
    unique case (in_action)
      ACT_SCHEDULE: begin
        run_req   = in_range && !in_act;
        in_status = run_req ? STAT_OK : STAT_NOT_FREE;
      end
      ACT_RESCHEDULE, ACT_CANCEL, ACT_QUERY: begin
        run_req   = in_act;
        in_status = in_act ? STAT_OK : STAT_NOT_ACTIVE;
      end
      default: begin
        run_req   = 1'b0;
        in_status = STAT_OK;
      end
    endcase
  end

  // Next state and handshake.
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = run_req ? ST_RUN : ST_FIN;
        end
      end
      ST_RUN: begin
        if (chain_done && !second) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Head of the list is always the first cell.
  assign head_valid = cell_valid[0];
  assign head_slot  = head_valid ? SLOT_W'(cell_slot[0]) : '0;
  assign head_delay = head_valid ? DELAY_W'(cell_delta[0]) : '0;
  assign remaining  = op_query ? REM_W'(rem) : '0;

  // State, slot flags, token launch and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      active     <= '0;
      launch_ctl <= '{valid: 1'b0, mode: TOK_PASS};
      second     <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      // The output word is loaded once the operation finishes and the register is free.
      if (state == ST_FIN && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      // After the unlink pass of a reschedule, send the insert token.
      if (state == ST_RUN && chain_done && second) begin
        launch_ctl <= '{valid: 1'b1, mode: TOK_SEEK_INS};
      end else if (!(accept && run_req)) begin
        launch_ctl.valid <= 1'b0;
      end
      if (accept) begin
        second <= (in_action == ACT_RESCHEDULE) && in_act;
        unique case (in_action)
          ACT_SCHEDULE: begin
            if (run_req) begin
              active[in_idx] <= 1'b1;
              launch_ctl     <= '{valid: 1'b1, mode: TOK_SEEK_INS};
            end
          end
          ACT_RESCHEDULE: begin
            if (run_req) begin
              launch_ctl <= '{valid: 1'b1, mode: TOK_SEEK_DEL};
            end
          end
          ACT_CANCEL: begin
            if (run_req) begin
              active[in_idx] <= 1'b0;
              launch_ctl     <= '{valid: 1'b1, mode: TOK_SEEK_DEL};
            end
          end
          ACT_QUERY: begin
            if (run_req) begin
              launch_ctl <= '{valid: 1'b1, mode: TOK_SUM};
            end
          end
          ACT_CLEAR: begin
            active <= '0;
          end
          default: begin
          end
        endcase
      end else if (state == ST_RUN && chain_done && second) begin
        second <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_slot     <= in_idx;
      op_time     <= in_time;
      op_status   <= in_status;
      op_query    <= (in_action == ACT_QUERY) && in_act;
      launch_slot <= in_idx;
      launch_val  <= (in_action == ACT_SCHEDULE) ? in_time : '0;
    end
    if (state == ST_RUN && chain_done) begin
      rem <= tok_val[NUM_ALARMS];
      if (second) begin
        launch_slot <= op_slot;
        launch_val  <= op_time;
      end
    end
    if (state == ST_FIN && out_free) begin
      m_tdata <= M_TDATA_W'({head_delay, head_slot, head_valid, remaining, op_status});
    end
  end

  assign tok_ctl[0]  = launch_ctl;
  assign tok_slot[0] = launch_slot;
  assign tok_val[0]  = launch_val;

  // The cell row, in list order from the head.
  for (genvar i = 0; i < NUM_ALARMS; i++) begin : g_cell
    if (i < NUM_ALARMS - 1) begin : g_mid
      assign nxt_valid[i] = cell_valid[i+1];
      assign nxt_slot[i]  = cell_slot[i+1];
      assign nxt_delta[i] = cell_delta[i+1];
    end else begin : g_last
      assign nxt_valid[i] = 1'b0;
      assign nxt_slot[i]  = '0;
      assign nxt_delta[i] = '0;
    end

    radq_cell #(
      .SLOT_BITS (SLOT_BITS),
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .clear        (clear_all),
      .tok_in       (tok_ctl[i]),
      .tok_in_slot  (tok_slot[i]),
      .tok_in_val   (tok_val[i]),
      .nxt_valid    (nxt_valid[i]),
      .nxt_slot     (nxt_slot[i]),
      .nxt_delta    (nxt_delta[i]),
      .tok_out      (tok_ctl[i+1]),
      .tok_out_slot (tok_slot[i+1]),
      .tok_out_val  (tok_val[i+1]),
      .valid        (cell_valid[i]),
      .slot         (cell_slot[i]),
      .delta        (cell_delta[i])
    );
  end

`ifndef ASSERT_OFF
  // A token leaves the row only while an operation is running.
  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    chain_done |-> (state == ST_RUN))
    else $error("token left the cell row outside of a running operation");

  // Tokens are launched one at a time.
  a_launch_pulse: assert property (@(posedge clk) disable iff (rst)
    launch_ctl.valid |=> !launch_ctl.valid)
    else $error("two tokens launched back to back");

  // Outside of a walk, the row holds as many entries as there are active slots.
  a_row_matches_flags: assert property (@(posedge clk) disable iff (rst)
    (state != ST_RUN && !launch_ctl.valid) |->
      ($countones(cell_valid) == $countones(active)))
    else $error("cell row and active slot flags disagree");

  // A finished operation reaches the output register once it is free.
  a_fin_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && out_free) |=> m_tvalid)
    else $error("finished operation did not load the output register");
`endif

endmodule

`default_nettype wire
